### sv/mcrs_pkg.sv
// Package for the minimum connecting radius search block.
// Holds the controller state type, the command and status structs and fixed widths.
// No dependencies.
package mcrs_pkg;

   localparam int LIMIT_W = 33;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 33'd1000000000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_CLEAR,
      ST_WINIT,
      ST_POP,
      ST_UADDR,
      ST_ULATCH,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic srch_init;
      logic set_mid;
      logic clr;
      logic walk_init;
      logic pop;
      logic rd_u;
      logic latch_u;
      logic scan;
      logic decide;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic search_done;
      logic clr_last;
      logic scan_last;
      logic pipe_empty;
      logic stack_empty;
   } status_type;

endpackage

### sv/min_connect_radius_search.sv
// Top level of the minimum connecting radius search block.
// Instantiates mcrs_ctrl and mcrs_dp; uses mcrs_pkg.
//
// Points are loaded one beat per cycle while busy is low; the beat with req_is_last
// high closes the set and starts a binary search over the squared threshold, from
// zero up to the configured search limit. Each probe clears the visited marks,
// then walks the graph from point 0: every popped point passes through pop,
// address, latch, a scan of all n points and a drain of the shared distance
// pipeline, as all n points pass through one read port of the point stores.
// At most n points are popped per probe, and the search runs ceil(log2(limit + 1))
// probes, at most 33 (30 at the reset limit).
// The result appears on rsp_ for one cycle with rsp_valid high; the receiver
// cannot stall it and must take it then. The csr_ channel is always ready and
// should be written only while the block is idle.
module min_connect_radius_search #(
   parameter int MAX_POINTS = 1024,
   parameter int COORD_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [COORD_BITS-1:0]         req_x_coord,
   input  logic [COORD_BITS-1:0]         req_y_coord,
   input  logic                          req_is_last,
   output logic                          rsp_valid,
   output logic [mcrs_pkg::LIMIT_W-1:0]  rsp_min_squared_range,
   output logic                          rsp_limit_reached,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mcrs_pkg::LIMIT_W-1:0]  csr_data
);
   import mcrs_pkg::*;

   cmd_type    cmd;
   status_type status;

   // The limit register can take a write in any cycle.
   assign csr_ready = 1'b1;

   mcrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .is_last   (req_is_last),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   mcrs_dp #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .x_coord           (req_x_coord),
      .y_coord           (req_y_coord),
      .csr_write         (csr_valid && csr_ready),
      .csr_data          (csr_data),
      .min_squared_range (rsp_min_squared_range),
      .limit_reached     (rsp_limit_reached)
   );

endmodule

### sv/mcrs_ctrl.sv
// Controller state machine of the minimum connecting radius search.
// Sequences loading, binary search probes and graph walks; uses mcrs_pkg.
module mcrs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 is_last,
   input  mcrs_pkg::status_type status,
   output mcrs_pkg::cmd_type    cmd,
   output logic                 busy,
   output logic                 rsp_valid
);
   import mcrs_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               if (is_last) begin
                  cmd.srch_init = 1'b1;
                  state_in      = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (status.search_done) begin
               state_in = ST_DONE;
            end else begin
               cmd.set_mid = 1'b1;
               state_in    = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            cmd.clr = 1'b1;
            if (status.clr_last) state_in = ST_WINIT;
         end
         ST_WINIT: begin
            cmd.walk_init = 1'b1;
            state_in      = ST_POP;
         end
         ST_POP: begin
            cmd.pop  = 1'b1;
            state_in = ST_UADDR;
         end
         ST_UADDR: begin
            cmd.rd_u = 1'b1;
            state_in = ST_ULATCH;
         end
         ST_ULATCH: begin
            cmd.latch_u = 1'b1;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (status.pipe_empty) begin
               state_in = status.stack_empty ? ST_DECIDE : ST_POP;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_SEARCH;
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            rsp_valid  = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

### sv/mcrs_dp.sv
// Datapath of the minimum connecting radius search: point stores, visited marks,
// walk stack, distance pipeline and binary search bounds. Uses mcrs_pkg.
module mcrs_dp #(
   parameter int MAX_POINTS = 1024,
   parameter int COORD_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mcrs_pkg::cmd_type             cmd,
   output mcrs_pkg::status_type          status,
   input  logic [COORD_BITS-1:0]         x_coord,
   input  logic [COORD_BITS-1:0]         y_coord,
   input  logic                          csr_write,
   input  logic [mcrs_pkg::LIMIT_W-1:0]  csr_data,
   output logic [mcrs_pkg::LIMIT_W-1:0]  min_squared_range,
   output logic                          limit_reached
);
   import mcrs_pkg::*;

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int SQ_W  = 2 * COORD_BITS;
   localparam int SW    = SQ_W + 1;
   localparam int CMP_W = (SW > LIMIT_W) ? SW : LIMIT_W;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

   logic [COORD_BITS-1:0] x_mem [MAX_POINTS];
   logic [COORD_BITS-1:0] y_mem [MAX_POINTS];
   logic                  vis_mem [MAX_POINTS];
   logic [IDX_W-1:0]      stk_mem [MAX_POINTS];

   logic [LIMIT_W-1:0] limit_ff, low_ff, high_ff, thr_ff;
   logic [CNT_W-1:0]   cnt_ff, top_ff, reached_ff;
   logic [IDX_W-1:0]   clr_ff, scan_ff, u_ff;
   logic [COORD_BITS-1:0] rd_x_ff, rd_y_ff, xu_ff, yu_ff;
   logic               rd_vis_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic [CNT_W-1:0]   n_minus1;

   // Scan pipeline: stage 1 is the memory read, stage 2 the differences,
   // stage 3 the squares; the link decision is taken from stage 3.
   logic               vld1_ff, vld2_ff, vld3_ff;
   logic [IDX_W-1:0]   v1_ff, v2_ff, v3_ff;
   logic               vis2_ff, vis3_ff;
   logic [COORD_BITS-1:0] dx_ff, dy_ff;
   logic [SQ_W-1:0]    sqx_ff, sqy_ff;
   logic [SW-1:0]      sum_sq;
   logic               link;

   function automatic logic [IDX_W-1:0] n_top_idx(input logic [CNT_W-1:0] t);
      logic [CNT_W-1:0] d;
      d = t - CNT_W'(1);
      return d[IDX_W-1:0];
   endfunction

   assign n_minus1 = cnt_ff - CNT_W'(1);
   assign rd_addr  = cmd.scan ? scan_ff : u_ff;
   assign sum_sq   = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign link     = vld3_ff && !vis3_ff && (CMP_W'(sum_sq) <= CMP_W'(thr_ff));

   always_comb begin
      status.search_done = !(low_ff < high_ff);
      status.clr_last    = (CNT_W'(clr_ff) == n_minus1);
      status.scan_last   = (CNT_W'(scan_ff) == n_minus1);
      status.pipe_empty  = !vld1_ff && !vld2_ff && !vld3_ff;
      status.stack_empty = (top_ff == '0);
   end

   assign min_squared_range = low_ff;
   assign limit_reached     = (low_ff >= limit_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= LIMIT_RESET;
         cnt_ff     <= '0;
         low_ff     <= '0;
         high_ff    <= '0;
         top_ff     <= '0;
         reached_ff <= '0;
         vld1_ff    <= 1'b0;
         vld2_ff    <= 1'b0;
         vld3_ff    <= 1'b0;
      end else begin
         if (csr_write) limit_ff <= csr_data;
         if (cmd.load && cnt_ff < MAX_CNT) cnt_ff <= cnt_ff + CNT_W'(1);
         if (cmd.finish) cnt_ff <= '0;
         if (cmd.srch_init) begin
            low_ff  <= '0;
            high_ff <= limit_ff;
         end
         if (cmd.decide) begin
            if (reached_ff == cnt_ff) high_ff <= thr_ff;
            else                      low_ff  <= thr_ff + LIMIT_W'(1);
         end
         if (cmd.walk_init) begin
            top_ff     <= CNT_W'(1);
            reached_ff <= CNT_W'(1);
         end else if (cmd.pop) begin
            top_ff <= top_ff - CNT_W'(1);
         end else if (link) begin
            top_ff     <= top_ff + CNT_W'(1);
            reached_ff <= reached_ff + CNT_W'(1);
         end
         vld1_ff <= cmd.scan;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
   end

   // Payload registers and counters that need no reset.
   always_ff @(posedge clock) begin
      if (cmd.set_mid) begin
         thr_ff <= low_ff + ((high_ff - low_ff) >> 1);
         clr_ff <= '0;
      end
      if (cmd.clr) clr_ff <= clr_ff + IDX_W'(1);
      if (cmd.latch_u) begin
         xu_ff   <= rd_x_ff;
         yu_ff   <= rd_y_ff;
         scan_ff <= '0;
      end
      if (cmd.scan) scan_ff <= scan_ff + IDX_W'(1);
      v1_ff   <= scan_ff;
      v2_ff   <= v1_ff;
      v3_ff   <= v2_ff;
      vis2_ff <= rd_vis_ff;
      vis3_ff <= vis2_ff;
      dx_ff   <= (rd_x_ff > xu_ff) ? rd_x_ff - xu_ff : xu_ff - rd_x_ff;
      dy_ff   <= (rd_y_ff > yu_ff) ? rd_y_ff - yu_ff : yu_ff - rd_y_ff;
      sqx_ff  <= SQ_W'(dx_ff) * SQ_W'(dx_ff);
      sqy_ff  <= SQ_W'(dy_ff) * SQ_W'(dy_ff);
   end

   // Point stores.
   always_ff @(posedge clock) begin
      if (cmd.load && cnt_ff < MAX_CNT) begin
         x_mem[cnt_ff[IDX_W-1:0]] <= x_coord;
         y_mem[cnt_ff[IDX_W-1:0]] <= y_coord;
      end
      rd_x_ff <= x_mem[rd_addr];
      rd_y_ff <= y_mem[rd_addr];
   end

   // Visited marks.
   always_ff @(posedge clock) begin
      if (cmd.clr)            vis_mem[clr_ff] <= 1'b0;
      else if (cmd.walk_init) vis_mem['0]     <= 1'b1;
      else if (link)          vis_mem[v3_ff]  <= 1'b1;
      rd_vis_ff <= vis_mem[rd_addr];
   end

   // Walk stack; the popped entry lands in u_ff.
   always_ff @(posedge clock) begin
      if (cmd.walk_init) stk_mem['0] <= '0;
      else if (link)     stk_mem[top_ff[IDX_W-1:0]] <= v3_ff;
      if (cmd.pop) u_ff <= stk_mem[n_top_idx(top_ff)];
   end

endmodule

### sim/mcrs_checker.sv
// Checker for the minimum connecting radius search block: it watches the point,
// result and register channels, predicts each result and compares it.
// Depends on mcrs_pkg for the limit width and its reset value.
module mcrs_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [15:0]                  req_x_coord,
   input  logic [15:0]                  req_y_coord,
   input  logic                         req_is_last,
   input  logic                         rsp_valid,
   input  logic [mcrs_pkg::LIMIT_W-1:0] rsp_min_squared_range,
   input  logic                         rsp_limit_reached,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [mcrs_pkg::LIMIT_W-1:0] csr_data,
   output int                           error_count,
   output int                           pending_ranges
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_PTS = 1024;

   typedef struct {
      logic [mcrs_pkg::LIMIT_W-1:0] range;
      logic                         capped;
   } range_result_type;

   logic [mcrs_pkg::LIMIT_W-1:0] limit_copy;
   logic [15:0]                  set_x[$];
   logic [15:0]                  set_y[$];
   range_result_type             range_queue[$];

   // Largest link on a minimum spanning tree of the set, grown greedily from point 0.
   function automatic longint unsigned bottleneck_range();
      longint unsigned best[MAX_PTS];
      bit              joined[MAX_PTS];
      longint unsigned worst;
      longint unsigned dx, dy, sq_len, pick_val;
      int              n, pick;
      n = set_x.size();
      worst = 0;
      for (int i = 0; i < n; i++) begin
         best[i] = 64'hFFFF_FFFF_FFFF_FFFF;
         joined[i] = 0;
      end
      best[0] = 0;
      for (int k = 0; k < n; k++) begin
         pick = -1;
         pick_val = 64'hFFFF_FFFF_FFFF_FFFF;
         for (int i = 0; i < n; i++) begin
            if (!joined[i] && (pick < 0 || best[i] < pick_val)) begin
               pick = i;
               pick_val = best[i];
            end
         end
         joined[pick] = 1;
         if (pick_val > worst) worst = pick_val;
         for (int i = 0; i < n; i++) begin
            if (!joined[i]) begin
               dx = (set_x[i] > set_x[pick]) ? set_x[i] - set_x[pick] : set_x[pick] - set_x[i];
               dy = (set_y[i] > set_y[pick]) ? set_y[i] - set_y[pick] : set_y[pick] - set_y[i];
               sq_len = dx * dx + dy * dy;
               if (sq_len < best[i]) best[i] = sq_len;
            end
         end
      end
      return worst;
   endfunction

   assign pending_ranges = range_queue.size();

   always @(posedge clock) begin
      range_result_type want;
      longint unsigned  thr;
      if (reset) begin
         limit_copy <= mcrs_pkg::LIMIT_RESET;
         set_x.delete();
         set_y.delete();
         range_queue.delete();
         error_count <= 0;
      end else begin
         if (csr_valid && csr_ready) limit_copy <= csr_data;
         if (start && !busy) begin
            if (set_x.size() < MAX_PTS) begin
               set_x = {set_x, req_x_coord};
               set_y = {set_y, req_y_coord};
            end
            if (req_is_last) begin
               thr = bottleneck_range();
               if (thr >= limit_copy) begin
                  want.range = limit_copy;
                  want.capped = 1;
               end else begin
                  want.range = mcrs_pkg::LIMIT_W'(thr);
                  want.capped = 0;
               end
               range_queue = {range_queue, want};
               set_x.delete();
               set_y.delete();
            end
         end
         if (rsp_valid) begin
            if (range_queue.size() == 0) begin
               if (error_count < 10) $display("unexpected result beat: range %0d flag %0d",
                                              rsp_min_squared_range, rsp_limit_reached);
               error_count <= error_count + 1;
            end else begin
               want = range_queue.pop_front();
               if (want.range !== rsp_min_squared_range || want.capped !== rsp_limit_reached)
               begin
                  if (error_count < 10)
                     $display("mismatch: range exp %0d got %0d, flag exp %0d got %0d",
                              want.range, rsp_min_squared_range, want.capped,
                              rsp_limit_reached);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end
endmodule

### sim/tb_top.sv
// Top of the testbench for the minimum connecting radius search block.
// Drives point sets and limit writes; mcrs_checker (with mcrs_pkg) predicts and checks.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic                         clock = 0;
   logic                         reset = 1;
   logic                         start = 0;
   logic                         busy;
   logic [15:0]                  req_x_coord = 0;
   logic [15:0]                  req_y_coord = 0;
   logic                         req_is_last = 0;
   logic                         rsp_valid;
   logic [mcrs_pkg::LIMIT_W-1:0] rsp_min_squared_range;
   logic                         rsp_limit_reached;
   logic                         csr_valid = 0;
   logic                         csr_ready;
   logic [mcrs_pkg::LIMIT_W-1:0] csr_data = 0;
   int                           error_count;
   int                           pending_ranges;
   int                           points_sent;

   localparam logic [32:0] LIMIT_TOP = 33'h1_FFFF_FFFF;

   always #6 clock = ~clock;

   min_connect_radius_search dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_x_coord(req_x_coord), .req_y_coord(req_y_coord), .req_is_last(req_is_last),
      .rsp_valid(rsp_valid), .rsp_min_squared_range(rsp_min_squared_range),
      .rsp_limit_reached(rsp_limit_reached),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   mcrs_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_x_coord(req_x_coord), .req_y_coord(req_y_coord), .req_is_last(req_is_last),
      .rsp_valid(rsp_valid), .rsp_min_squared_range(rsp_min_squared_range),
      .rsp_limit_reached(rsp_limit_reached),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .error_count(error_count), .pending_ranges(pending_ranges)
   );

   // Present one point beat at a falling edge and hold it until the block takes it.
   // Start stays high into the next beat when the drawn gap is zero, so it is
   // never lowered and raised within one time step.
   task automatic send_point(input logic [15:0] x, input logic [15:0] y, input logic last);
      int gap;
      @(negedge clock);
      start = 1;
      req_x_coord = x;
      req_y_coord = y;
      req_is_last = last;
      @(posedge clock);
      while (busy) @(posedge clock);
      points_sent++;
      gap = int'($urandom_range(0, 13));
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         @(negedge clock);
         start = 0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // The limit register is written only while the block is idle with nothing pending.
   task automatic write_limit(input logic [32:0] value);
      @(negedge clock);
      start = 0;
      while (pending_ranges != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid = 1;
      csr_data = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 0;
   endtask

   // A whole set of random points; the style picks full-range, clustered,
   // corner-heavy or duplicated coordinates so both capped and uncapped answers occur.
   task automatic send_set(input int count);
      int          style;
      logic [15:0] x, y;
      style = int'($urandom_range(0, 3));
      for (int i = 0; i < count; i++) begin
         case (style)
            0: begin
               x = 16'($urandom);
               y = 16'($urandom);
            end
            1: begin
               x = 16'($urandom_range(0, 255));
               y = 16'($urandom_range(0, 255));
            end
            2: begin
               x = $urandom_range(0, 1) ? 16'hFFFF - 16'($urandom_range(0, 15))
                                        : 16'($urandom_range(0, 15));
               y = $urandom_range(0, 1) ? 16'hFFFF - 16'($urandom_range(0, 15))
                                        : 16'($urandom_range(0, 15));
            end
            default: begin
               x = 16'h1234 + 16'($urandom_range(0, 2));
               y = 16'hFEDC - 16'($urandom_range(0, 2));
            end
         endcase
         send_point(x, y, i == count - 1);
      end
   endtask

   function automatic logic [32:0] pick_limit();
      case ($urandom_range(0, 6))
         0: return 33'd1;
         1: return mcrs_pkg::LIMIT_RESET;
         2: return LIMIT_TOP;
         3: return 33'($urandom_range(2, 200000));
         4: return {1'($urandom_range(0, 1)), 32'($urandom)};
         default: return 33'($urandom_range(1000000, 40000000));
      endcase
   endfunction

   initial begin
      int size;
      int set_index;
      points_sent = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed part, first with the reset limit: a single point, two opposite
      // corners (capped), duplicates, and a pair one unit apart.
      send_point(16'h0000, 16'h0000, 1);
      send_point(16'h0000, 16'h0000, 0);
      send_point(16'hFFFF, 16'hFFFF, 1);
      send_point(16'h8000, 16'h8000, 0);
      send_point(16'h8000, 16'h8000, 1);
      send_point(16'h0005, 16'h0007, 0);
      send_point(16'h0006, 16'h0007, 1);
      // The widest limit lets the farthest corners connect below it.
      write_limit(LIMIT_TOP);
      send_point(16'h0000, 16'h0000, 0);
      send_point(16'hFFFF, 16'hFFFF, 1);
      send_point(16'hFFFF, 16'h0000, 1);
      // A zero limit caps everything, even a single point.
      write_limit(33'd0);
      send_point(16'h0100, 16'h0200, 1);
      send_point(16'h0000, 16'h0000, 0);
      send_point(16'h0003, 16'h0004, 1);
      // A limit of one caps both a unit step and a diagonal step.
      write_limit(33'd1);
      send_point(16'h0010, 16'h0010, 0);
      send_point(16'h0011, 16'h0010, 1);
      send_point(16'h0010, 16'h0010, 0);
      send_point(16'h0011, 16'h0011, 1);
      write_limit(mcrs_pkg::LIMIT_RESET);

      // Hold the sender off until every expected result has come back.
      @(negedge clock);
      start = 0;
      while (pending_ranges != 0) @(negedge clock);

      // Random part: mostly small sets, since the search cost grows with the square of
      // the set size, with a rare larger one and a new limit every dozen sets.
      set_index = 0;
      while (points_sent < 1650) begin
         if (set_index % 12 == 11) write_limit(pick_limit());
         if ($urandom_range(0, 299) == 0) size = int'($urandom_range(24, 40));
         else if ($urandom_range(0, 3) == 0) size = int'($urandom_range(6, 10));
         else size = int'($urandom_range(1, 5));
         send_set(size);
         set_index++;
      end

      @(negedge clock);
      start = 0;
      req_is_last = 0;
      while (pending_ranges != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (error_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   initial begin
      #500ms;
      $display("tb: failure");
      $finish;
   end
endmodule

### files.f
sv/mcrs_pkg.sv
sv/mcrs_ctrl.sv
sv/mcrs_dp.sv
sv/min_connect_radius_search.sv
sim/mcrs_checker.sv
sim/tb_top.sv
